// File: sv/bpgc_pkg.sv
// ----------------------------------------------------------------------------
// bpgc_pkg
// shared types, register codes and reset values of the press classifier
// ----------------------------------------------------------------------------
package bpgc_pkg;

    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int NUM_BUTTONS_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF    = 2'd2;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;
    localparam logic [CFG_W-1:0] DOUBLE_TAP_RST = 16'd300;
    localparam logic [CFG_W-1:0] HOLDOFF_RST    = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] double_tap_ms;
    } lane_cfg_t;

    typedef struct packed {
        logic              update;
        logic [TIME_W-1:0] now_ms;
    } lane_cmd_t;

    typedef struct packed {
        logic long_press;
        logic double_press;
        logic short_press;
    } lane_fire_t;

endpackage

// File: sv/bpgc_lane.sv
// ----------------------------------------------------------------------------
// bpgc_lane
// one button: edge detection, press timing and short/long/double decision
// ----------------------------------------------------------------------------
module bpgc_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bpgc_pkg::lane_cfg_t   cfg,
    input  bpgc_pkg::lane_cmd_t   cmd,
    input  logic                  level,
    output bpgc_pkg::lane_fire_t  fire
);
    import bpgc_pkg::*;

    logic              prev_level_reg, prev_level_next;
    logic              tap_valid_reg, tap_valid_next;
    logic              pending_reg, pending_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    logic [TIME_W-1:0] last_tap_reg, last_tap_next;
    logic [TIME_W-1:0] expiry_reg, expiry_next;

    logic              rise, fall;
    logic [TIME_W-1:0] held, since_tap, since_expiry;
    logic              is_long, is_dbl, is_tap;
    logic              fire_short;

    always_comb begin
        rise         = level && !prev_level_reg;
        fall         = !level && prev_level_reg;
        held         = cmd.now_ms - press_time_reg;
        since_tap    = cmd.now_ms - last_tap_reg;
        since_expiry = cmd.now_ms - expiry_reg;

        is_long = fall && (held >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms});
        is_dbl  = fall && !is_long && tap_valid_reg &&
                  (since_tap <= {{(TIME_W-CFG_W){1'b0}}, cfg.double_tap_ms});
        is_tap  = fall && !is_long && !is_dbl;

        // new tap fires at once only with a zero window
        if (is_tap) begin
            fire_short = (cfg.double_tap_ms == '0);
        end else begin
            fire_short = pending_reg && !is_dbl && !since_expiry[TIME_W-1];
        end

        prev_level_next = level;
        press_time_next = rise ? cmd.now_ms : press_time_reg;
        tap_valid_next  = tap_valid_reg;
        last_tap_next   = last_tap_reg;
        expiry_next     = expiry_reg;
        pending_next    = pending_reg;

        if (is_dbl) begin
            tap_valid_next = 1'b0;
            last_tap_next  = '0;
            pending_next   = 1'b0;
        end else if (is_tap) begin
            tap_valid_next = 1'b1;
            last_tap_next  = cmd.now_ms;
            pending_next   = 1'b1;
            expiry_next    = cmd.now_ms + {{(TIME_W-CFG_W){1'b0}}, cfg.double_tap_ms};
        end
        if (fire_short) begin
            pending_next = 1'b0;
        end

        fire.long_press   = cmd.update && is_long;
        fire.double_press = cmd.update && is_dbl;
        fire.short_press  = cmd.update && fire_short;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            tap_valid_reg  <= 1'b0;
            pending_reg    <= 1'b0;
        end else if (cmd.update) begin
            prev_level_reg <= prev_level_next;
            tap_valid_reg  <= tap_valid_next;
            pending_reg    <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            press_time_reg <= press_time_next;
            last_tap_reg   <= last_tap_next;
            expiry_reg     <= expiry_next;
        end
    end

endmodule

// File: sv/bpgc_merge.sv
// ----------------------------------------------------------------------------
// bpgc_merge
// gathers lane decisions into masks and holds the result item for the sink
// ----------------------------------------------------------------------------
module bpgc_merge #(
    parameter int NUM_BUTTONS = bpgc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  bpgc_pkg::lane_fire_t       fire [NUM_BUTTONS],
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [NUM_BUTTONS-1:0]     m_long_mask,
    output logic [NUM_BUTTONS-1:0]     m_double_mask,
    output logic [NUM_BUTTONS-1:0]     m_short_mask
);
    import bpgc_pkg::*;

    logic                   valid_reg, valid_next;
    logic [NUM_BUTTONS-1:0] long_reg, long_next;
    logic [NUM_BUTTONS-1:0] double_reg, double_next;
    logic [NUM_BUTTONS-1:0] short_reg, short_next;

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            long_next[i]   = fire[i].long_press;
            double_next[i] = fire[i].double_press;
            short_next[i]  = fire[i].short_press;
        end
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            long_reg   <= long_next;
            double_reg <= double_next;
            short_reg  <= short_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_long_mask   = long_reg;
    assign m_double_mask = double_reg;
    assign m_short_mask  = short_reg;

endmodule

// File: sv/button_press_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_press_gesture_classifier
// short, long and double press detection for a bank of debounced buttons
// ----------------------------------------------------------------------------
// input item: s_now_ms (ms timestamp, wraps at 32 bits) and s_pressed_levels,
// one bit per button. every item gives exactly one result item carrying the
// long, double and short press masks fired by that item.
// latency: the result is valid in the cycle after the item is taken.
// throughput: one item per cycle; each button has its own lane of compares
// and timing registers, and one output register collects the lane masks.
// s_ready is high while the output register is empty or being taken, so a
// stalled sink holds the result and blocks only the next item.
// the first item sets the start time; items less than holdoff_ms after it
// change nothing and give all-zero masks.
// configuration: cfg_wr_en writes the low 16 bits of cfg_wdata into register
// cfg_index (0 long press, 1 double tap, 2 holdoff); other indexes are ignored.
// write only while no item is in flight.
// reset (aresetn low, synchronous): registers return to 500/300/1000 ms, all
// buttons released, nothing pending, output empty.
// ----------------------------------------------------------------------------
module button_press_gesture_classifier #(
    parameter int NUM_BUTTONS = bpgc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bpgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpgc_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bpgc_pkg::TIME_W-1:0]       s_now_ms,
    input  logic [NUM_BUTTONS-1:0]            s_pressed_levels,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [NUM_BUTTONS-1:0]            m_long_mask,
    output logic [NUM_BUTTONS-1:0]            m_double_mask,
    output logic [NUM_BUTTONS-1:0]            m_short_mask
);
    import bpgc_pkg::*;

    logic [CFG_W-1:0]  long_press_reg;
    logic [CFG_W-1:0]  double_tap_reg;
    logic [CFG_W-1:0]  holdoff_reg;
    logic              started_reg;
    logic [TIME_W-1:0] start_time_reg;

    logic              s_accept;
    logic [TIME_W-1:0] origin;
    logic [TIME_W-1:0] elapsed;
    logic              active;
    lane_cfg_t         lane_cfg;
    lane_cmd_t         lane_cmd;
    lane_fire_t        fire [NUM_BUTTONS];

    assign s_ready  = !m_valid || m_ready;
    assign s_accept = s_valid && s_ready;

    // holdoff gate
    always_comb begin
        origin  = started_reg ? start_time_reg : s_now_ms;
        elapsed = s_now_ms - origin;
        active  = elapsed >= {{(TIME_W-CFG_W){1'b0}}, holdoff_reg};

        lane_cfg.long_press_ms = long_press_reg;
        lane_cfg.double_tap_ms = double_tap_reg;
        lane_cmd.update        = s_accept && active;
        lane_cmd.now_ms        = s_now_ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg <= LONG_PRESS_RST;
            double_tap_reg <= DOUBLE_TAP_RST;
            holdoff_reg    <= HOLDOFF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                REG_DOUBLE_TAP: double_tap_reg <= cfg_wdata;
                REG_HOLDOFF:    holdoff_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            start_time_reg <= '0;
        end else if (s_accept && !started_reg) begin
            started_reg    <= 1'b1;
            start_time_reg <= s_now_ms;
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        bpgc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (lane_cfg),
            .cmd     (lane_cmd),
            .level   (s_pressed_levels[i]),
            .fire    (fire[i])
        );
    end

    bpgc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (s_accept),
        .fire          (fire),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_long_mask   (m_long_mask),
        .m_double_mask (m_double_mask),
        .m_short_mask  (m_short_mask)
    );

    a_first_item_holdoff: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !started_reg && holdoff_reg != '0 |=>
            m_valid && m_long_mask == '0 && m_double_mask == '0 && m_short_mask == '0)
        else $error("first item inside holdoff produced a press");

    a_started_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> started_reg)
        else $error("start time not recorded");

    a_double_excludes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_double_mask & m_long_mask) == '0 &&
                    (m_double_mask & m_short_mask) == '0)
        else $error("double press fired with another action on one button");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("item taken while result held");

endmodule

// File: tb/press_class_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// press_class_checker
// watches the item and result channels of the press classifier, keeps its own
// copy of the per-button timing state and register settings, works out the
// long, double and short masks for every accepted item and compares them in
// order with the results the block hands out
// ----------------------------------------------------------------------------
module press_class_checker #(
    parameter int NB = bpgc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bpgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpgc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [bpgc_pkg::TIME_W-1:0]    s_now_ms,
    input  logic [NB-1:0]                  s_pressed_levels,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [NB-1:0]                  m_long_mask,
    input  logic [NB-1:0]                  m_double_mask,
    input  logic [NB-1:0]                  m_short_mask,
    output int unsigned                    fail_count,
    output int unsigned                    open_count
);
    import bpgc_pkg::*;

    typedef struct packed {
        logic [NB-1:0] long_m;
        logic [NB-1:0] dbl_m;
        logic [NB-1:0] short_m;
    } press_masks_t;

    logic [CFG_W-1:0]  long_ms;
    logic [CFG_W-1:0]  tap_ms;
    logic [CFG_W-1:0]  hold_ms;
    logic              started;
    logic [TIME_W-1:0] start_t;
    logic [NB-1:0]     level_q;
    logic [NB-1:0]     tap_ok;
    logic [NB-1:0]     short_due;
    logic [TIME_W-1:0] pressed_at [NB];
    logic [TIME_W-1:0] last_tap [NB];
    logic [TIME_W-1:0] short_at [NB];
    press_masks_t      fired_q [$];
    int unsigned       miss_cnt = 0;

    function automatic press_masks_t classify_pass(input logic [TIME_W-1:0] now,
                                                   input logic [NB-1:0] lv);
        press_masks_t      r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] late;
        r = '0;
        if (!started) begin
            started = 1'b1;
            start_t = now;
        end
        elapsed = now - start_t;
        if (elapsed >= {16'd0, hold_ms}) begin
            for (int b = 0; b < NB; b++) begin
                if (lv[b] && !level_q[b])
                    pressed_at[b] = now;
                if (!lv[b] && level_q[b]) begin
                    held = now - pressed_at[b];
                    gap  = now - last_tap[b];
                    if (held >= {16'd0, long_ms}) begin
                        r.long_m[b] = 1'b1;
                    end else if (tap_ok[b] && gap <= {16'd0, tap_ms}) begin
                        last_tap[b]  = '0;
                        tap_ok[b]    = 1'b0;
                        short_due[b] = 1'b0;
                        r.dbl_m[b]   = 1'b1;
                    end else begin
                        last_tap[b]  = now;
                        tap_ok[b]    = 1'b1;
                        short_due[b] = 1'b1;
                        short_at[b]  = now + {16'd0, tap_ms};
                    end
                end
                level_q[b] = lv[b];
                // expiry reached when the wrapped difference is below half range
                late = now - short_at[b];
                if (short_due[b] && !late[TIME_W-1]) begin
                    short_due[b]  = 1'b0;
                    r.short_m[b]  = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic note_miss(input string msg);
        miss_cnt++;
        if (miss_cnt <= 10)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin : watch
        press_masks_t got;
        press_masks_t want;
        if (!aresetn) begin
            long_ms   = LONG_PRESS_RST;
            tap_ms    = DOUBLE_TAP_RST;
            hold_ms   = HOLDOFF_RST;
            started   = 1'b0;
            start_t   = '0;
            level_q   = '0;
            tap_ok    = '0;
            short_due = '0;
            for (int b = 0; b < NB; b++) begin
                pressed_at[b] = '0;
                last_tap[b]   = '0;
                short_at[b]   = '0;
            end
            fired_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LONG_PRESS: long_ms = cfg_wdata;
                    REG_DOUBLE_TAP: tap_ms  = cfg_wdata;
                    REG_HOLDOFF:    hold_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_long_mask, m_double_mask, m_short_mask};
                if (fired_q.size() == 0) begin
                    note_miss($sformatf("result item with none expected: long %b double %b short %b",
                                        got.long_m, got.dbl_m, got.short_m));
                end else begin
                    want = fired_q.pop_front();
                    if (got.long_m !== want.long_m)
                        note_miss($sformatf("long_mask expected %b got %b",
                                            want.long_m, got.long_m));
                    if (got.dbl_m !== want.dbl_m)
                        note_miss($sformatf("double_mask expected %b got %b",
                                            want.dbl_m, got.dbl_m));
                    if (got.short_m !== want.short_m)
                        note_miss($sformatf("short_mask expected %b got %b",
                                            want.short_m, got.short_m));
                end
            end
            if (s_valid && s_ready)
                fired_q.push_back(classify_pass(s_now_ms, s_pressed_levels));
        end
        fail_count <= miss_cnt;
        open_count <= fired_q.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// regression for the button press classifier: a directed run through holdoff,
// short, double and long presses, exact window edges and timer wrap, then
// random timestamped level sequences under several register settings and
// changing handshake pressure, checked item by item by press_class_checker
// ----------------------------------------------------------------------------
module tb;
    import bpgc_pkg::*;

    localparam int NB = NUM_BUTTONS_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int SEG_ITEMS = 140;
    localparam int NUM_SEGS = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TIME_W-1:0]    s_now_ms = '0;
    logic [NB-1:0]        s_pressed_levels = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [NB-1:0]        m_long_mask;
    logic [NB-1:0]        m_double_mask;
    logic [NB-1:0]        m_short_mask;

    int unsigned fail_count;
    int unsigned open_count;
    int unsigned sent_cnt = 0;
    int unsigned cycles = 0;
    int          s_idle_pct = 12;
    int          m_idle_pct = 55;
    bit          stall_done = 1'b0;

    logic [TIME_W-1:0] first_t;
    logic [TIME_W-1:0] cur_t;
    logic [NB-1:0]     cur_lv;
    logic [CFG_W-1:0]  cur_long = LONG_PRESS_RST;
    logic [CFG_W-1:0]  cur_tap = DOUBLE_TAP_RST;
    logic [CFG_W-1:0]  cur_hold = HOLDOFF_RST;

    initial begin
        forever #6 aclk = ~aclk;
    end

    button_press_gesture_classifier #(.NUM_BUTTONS(NB)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now_ms        (s_now_ms),
        .s_pressed_levels(s_pressed_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_long_mask     (m_long_mask),
        .m_double_mask   (m_double_mask),
        .m_short_mask    (m_short_mask)
    );

    press_class_checker #(.NB(NB)) u_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now_ms        (s_now_ms),
        .s_pressed_levels(s_pressed_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_long_mask     (m_long_mask),
        .m_double_mask   (m_double_mask),
        .m_short_mask    (m_short_mask),
        .fail_count      (fail_count),
        .open_count      (open_count)
    );

    // result side: random back-pressure, plus one long hold-off while items keep coming
    initial begin
        forever begin
            @(negedge aclk);
            if (!stall_done && sent_cnt >= 650) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                stall_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("button_press_gesture_classifier regression: fail");
            $finish;
        end
    end

    task automatic offer(input logic [TIME_W-1:0] t, input logic [NB-1:0] lv);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_now_ms         <= t;
        s_pressed_levels <= lv;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent_cnt++;
    endtask

    task automatic offer_random();
        int            pick;
        logic [NB-1:0] flip;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            cur_t += $urandom_range(0, 20);
        else if (pick < 65)
            cur_t += $urandom_range(0, 2 * int'(cur_long) + 2);
        else if (pick < 90)
            cur_t += $urandom_range(0, 2 * int'(cur_tap) + 2);
        else if (pick < 95)
            cur_t += $urandom;
        else
            cur_t = first_t + $urandom_range(0, int'(cur_hold) + 50);
        flip = '0;
        for (int b = 0; b < NB; b++)
            if ($urandom_range(0, 99) < 35)
                flip[b] = 1'b1;
        if ($urandom_range(0, 19) == 0)
            cur_lv = NB'($urandom);
        else
            cur_lv ^= flip;
        offer(cur_t, cur_lv);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (open_count == 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] dt,
                             input logic [CFG_W-1:0] ho);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        idx = '{REG_LONG_PRESS, REG_DOUBLE_TAP, REG_HOLDOFF, REG_SPARE};
        val = '{lp, dt, ho, CFG_W'($urandom)};
        for (int k = 0; k < 4; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_wdata <= val[k];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cur_long = lp;
        cur_tap  = dt;
        cur_hold = ho;
    endtask

    initial begin
        logic [TIME_W-1:0] d_off [22];
        logic [NB-1:0]     d_lv [22];
        d_off = '{32'd0, 32'd500, 32'd999, 32'd1000, 32'd1100, 32'd1200, 32'd1300,
                  32'd1350, 32'd1380, 32'd1650, 32'd1700, 32'd2200, 32'd2300, 32'd2799,
                  32'd3098, 32'd3099, 32'd3099, 32'd3200, 32'd3250,
                  32'd3550 + 32'h8000_0000, 32'd3550 + 32'h7FFF_FFFF, 32'd10};
        d_lv  = '{2'b11, 2'b00, 2'b11, 2'b11, 2'b10, 2'b10, 2'b11,
                  2'b01, 2'b00, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00,
                  2'b00, 2'b11, 2'b00, 2'b11, 2'b00,
                  2'b00, 2'b00, 2'b11};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // start time just below the wrap point, default register values
        first_t = 32'hFFFF_FC00;
        for (int i = 0; i < 22; i++) begin
            cur_t  = first_t + d_off[i];
            cur_lv = d_lv[i];
            offer(cur_t, cur_lv);
        end

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 2)
                0: begin
                    s_idle_pct = 12;
                    m_idle_pct = 55;
                end
                1: begin
                    s_idle_pct = 55;
                    m_idle_pct = 12;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                end
            endcase
            drain();
            case (seg)
                0: load_regs(16'hFFFF, 16'd0, 16'd0);
                1: load_regs(16'd0, 16'hFFFF, 16'hFFFF);
                2: load_regs(16'd1, 16'd1, 16'd1);
                default: load_regs(CFG_W'($urandom_range(1, 2000)),
                                   CFG_W'($urandom_range(0, 1000)),
                                   CFG_W'($urandom_range(0, 3000)));
            endcase
            repeat (SEG_ITEMS) offer_random();
        end

        s_valid <= 1'b0;
        wait (open_count == 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("button_press_gesture_classifier regression: pass");
        else
            $display("button_press_gesture_classifier regression: fail");
        $finish;
    end

endmodule

// File: button_press_gesture_classifier.f
sv/bpgc_pkg.sv
sv/bpgc_lane.sv
sv/bpgc_merge.sv
sv/button_press_gesture_classifier.sv
tb/press_class_checker.sv
tb/tb.sv
